// ===== design/ecnfv_pkg.sv =====
// ----------------------------------------------------------------------------
// ECN feedback validator package
// Shared widths, event and codepoint codes, and the beat layouts of the
// input and result streams.
// ----------------------------------------------------------------------------
package ecnfv_pkg;

    localparam int COUNT_BITS_DEF   = 62;
    localparam int FIELD_BITS       = 62;
    localparam int SUM_BITS         = 64;
    localparam int TOL_BITS         = 16;
    localparam int KIND_BITS        = 3;
    localparam int CP_BITS          = 2;
    localparam int PHASE_BITS       = 2;
    localparam int MIN_TEST_PACKETS = 10;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = TOL_BITS;

    localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(16);

    localparam int S_TDATA_BITS = 256;
    localparam int M_TDATA_BITS = 320;
    localparam int M_TUSER_BITS = 1;

    typedef enum logic [KIND_BITS-1:0] {
        EV_SENT       = 3'd0,
        EV_ACK        = 3'd1,
        EV_VALIDATE   = 3'd2,
        EV_CLEAR      = 3'd3,
        EV_BEGIN_TEST = 3'd4
    } ev_kind_t;

    typedef enum logic [CP_BITS-1:0] {
        CP_NOT_ECT = 2'd0,
        CP_ECT1    = 2'd1,
        CP_ECT0    = 2'd2,
        CP_CE      = 2'd3
    } codepoint_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_USE_L4S     = 1'b0,
        CFG_REORDER_TOL = 1'b1
    } cfg_index_t;

    // Input beat, first field in the lowest bits.
    typedef struct packed {
        logic [5:0]            pad;
        logic [FIELD_BITS-1:0] acked_count;
        logic [FIELD_BITS-1:0] peer_ce_total;
        logic [FIELD_BITS-1:0] peer_ect1_total;
        logic [FIELD_BITS-1:0] peer_ect0_total;
        codepoint_t            sent_codepoint;
    } in_beat_t;

    // Result beat, first field in the lowest bits.
    typedef struct packed {
        logic [1:0]            pad;
        codepoint_t            send_mark;
        logic                  mangling_seen;
        logic                  bleaching_seen;
        logic [PHASE_BITS-1:0] path_status;
        logic [SUM_BITS-1:0]   ce_accumulated;
        logic [FIELD_BITS-1:0] acked_pass;
        logic [FIELD_BITS-1:0] ce_inc;
        logic [FIELD_BITS-1:0] ect1_inc;
        logic [FIELD_BITS-1:0] ect0_inc;
    } out_beat_t;

endpackage

// ===== design/ecnfv_count_diff.sv =====
// ----------------------------------------------------------------------------
// ECN feedback validator count difference
// Forms the increase of a cumulative count and checks a decrease against
// the reordering tolerance; any decrease yields a zero increase.
// ----------------------------------------------------------------------------
module ecnfv_count_diff
    import ecnfv_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic [COUNT_BITS-1:0] now_count,
    input  logic [COUNT_BITS-1:0] prev_count,
    input  logic [TOL_BITS-1:0]   tolerance,
    output logic [COUNT_BITS-1:0] delta,
    output logic                  ok
);

    logic [COUNT_BITS:0]   diff;
    logic [COUNT_BITS-1:0] back;
    logic                  decrease;

    assign diff     = {1'b0, now_count} - {1'b0, prev_count};
    assign back     = prev_count - now_count;
    assign decrease = diff[COUNT_BITS];
    assign delta    = decrease ? '0 : diff[COUNT_BITS-1:0];
    assign ok       = !decrease || (back <= COUNT_BITS'(tolerance));

endmodule

// ===== design/ecn_feedback_validator.sv =====
// ----------------------------------------------------------------------------
// ECN feedback validator
// An accepted input beat passes the input register, then the result register.
// Throughput: one beat per cycle unless m_tready stalls the result register;
// the path state is updated in the single pass between the two registers.
// Reset: synchronous, active low; clears counts, flags and configuration
// (use_l4s 0, reorder tolerance 16) and takes the path state to unknown.
// ----------------------------------------------------------------------------
module ecn_feedback_validator
    import ecnfv_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,

    input  logic                     s_tvalid,
    output logic                     s_tready,
    // sent_codepoint, peer_ect0_total, peer_ect1_total, peer_ce_total,
    // acked_count, zero fill
    input  logic [S_TDATA_BITS-1:0]  s_tdata,
    // kind
    input  logic [KIND_BITS-1:0]     s_tuser,

    output logic                     m_tvalid,
    input  logic                     m_tready,
    // ECT(0) increase, ECT(1) increase, CE increase, acked count,
    // ce_accumulated, path_status, bleaching_seen, mangling_seen, send_mark,
    // zero fill
    output logic [M_TDATA_BITS-1:0]  m_tdata,
    // status
    output logic [M_TUSER_BITS-1:0]  m_tuser
);

    typedef enum logic [PHASE_BITS-1:0] {
        PH_UNKNOWN = 2'd0,
        PH_TESTING = 2'd1,
        PH_CAPABLE = 2'd2,
        PH_FAILED  = 2'd3
    } phase_t;

    in_beat_t  in_beat;
    out_beat_t out_beat;

    // Input register
    logic                  in_valid_reg;
    logic [KIND_BITS-1:0]  kind_reg;
    codepoint_t            cp_reg;
    logic [COUNT_BITS-1:0] p0_reg, p1_reg, pc_reg;
    logic [FIELD_BITS-1:0] acked_reg;

    // Configuration
    logic                  use_l4s_reg;
    logic [TOL_BITS-1:0]   tol_reg;

    // Path state
    phase_t                phase_reg, phase_next;
    logic                  ect0_allowed_reg, ect0_allowed_next;
    logic [COUNT_BITS-1:0] sent_ect0_reg, sent_ect0_next;
    logic [COUNT_BITS-1:0] sent_ect1_reg, sent_ect1_next;
    logic [COUNT_BITS-1:0] sent_ce_reg, sent_ce_next;
    logic [COUNT_BITS-1:0] last_ect0_reg, last_ect0_next;
    logic [COUNT_BITS-1:0] last_ect1_reg, last_ect1_next;
    logic [COUNT_BITS-1:0] last_ce_reg, last_ce_next;
    logic [COUNT_BITS-1:0] older_ect1_reg, older_ect1_next;
    logic [COUNT_BITS-1:0] test_pkts_reg, test_pkts_next;
    logic [SUM_BITS-1:0]   ce_sum_reg, ce_sum_next;
    logic                  bleach_reg, bleach_next;
    logic                  mangle_reg, mangle_next;

    // Result register
    logic                  out_valid_reg;
    logic                  status_reg, status_next;
    logic [COUNT_BITS-1:0] d0_reg, d0_next;
    logic [COUNT_BITS-1:0] d1_reg, d1_next;
    logic [COUNT_BITS-1:0] dc_reg, dc_next;
    logic [FIELD_BITS-1:0] na_reg, na_next;

    logic                  advance;
    logic [COUNT_BITS-1:0] diff0, diff1, diffc;
    logic                  ok0, ok1, okc, ok_all;
    logic [COUNT_BITS:0]   marked_tx;
    logic [COUNT_BITS+1:0] marked_rx;
    logic                  enough_recv;
    logic                  sent_any, none_reported;
    codepoint_t            send_mark;

    assign in_beat  = in_beat_t'(s_tdata);
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    ecnfv_count_diff #(.COUNT_BITS(COUNT_BITS)) u_diff_ect0 (
        .now_count  (p0_reg),
        .prev_count (last_ect0_reg),
        .tolerance  (tol_reg),
        .delta      (diff0),
        .ok         (ok0)
    );

    ecnfv_count_diff #(.COUNT_BITS(COUNT_BITS)) u_diff_ect1 (
        .now_count  (p1_reg),
        .prev_count (last_ect1_reg),
        .tolerance  (tol_reg),
        .delta      (diff1),
        .ok         (ok1)
    );

    ecnfv_count_diff #(.COUNT_BITS(COUNT_BITS)) u_diff_ce (
        .now_count  (pc_reg),
        .prev_count (last_ce_reg),
        .tolerance  (tol_reg),
        .delta      (diffc),
        .ok         (okc)
    );

    assign ok_all        = ok0 && ok1 && okc;
    assign marked_tx     = {1'b0, sent_ect0_reg} + {1'b0, sent_ect1_reg};
    assign marked_rx     = {2'b00, last_ect0_reg} + {2'b00, last_ect1_reg}
                         + {2'b00, last_ce_reg};
    assign enough_recv   = marked_rx >= {2'b00, marked_tx[COUNT_BITS:1]};
    assign sent_any      = (sent_ect0_reg != '0) || (sent_ect1_reg != '0);
    assign none_reported = (p0_reg == '0) && (p1_reg == '0) && (pc_reg == '0);

    always_comb begin
        phase_next        = phase_reg;
        ect0_allowed_next = ect0_allowed_reg;
        sent_ect0_next    = sent_ect0_reg;
        sent_ect1_next    = sent_ect1_reg;
        sent_ce_next      = sent_ce_reg;
        last_ect0_next    = last_ect0_reg;
        last_ect1_next    = last_ect1_reg;
        last_ce_next      = last_ce_reg;
        older_ect1_next   = older_ect1_reg;
        test_pkts_next    = test_pkts_reg;
        ce_sum_next       = ce_sum_reg;
        bleach_next       = bleach_reg;
        mangle_next       = mangle_reg;
        status_next       = 1'b0;
        d0_next           = '0;
        d1_next           = '0;
        dc_next           = '0;
        na_next           = '0;

        unique case (kind_reg)
            EV_SENT: begin
                case (cp_reg)
                    CP_ECT0: sent_ect0_next = sent_ect0_reg + 1'b1;
                    CP_ECT1: sent_ect1_next = sent_ect1_reg + 1'b1;
                    CP_CE:   sent_ce_next   = sent_ce_reg + 1'b1;
                    default: ;
                endcase
                if (phase_reg == PH_TESTING) begin
                    test_pkts_next = test_pkts_reg + 1'b1;
                end
            end
            EV_ACK: begin
                na_next = acked_reg;
                if (!ok_all) begin
                    status_next = 1'b1;
                end else begin
                    d0_next = diff0;
                    d1_next = diff1;
                    dc_next = diffc;
                    if (phase_reg == PH_TESTING || phase_reg == PH_CAPABLE) begin
                        if (sent_any && none_reported && acked_reg != '0) begin
                            bleach_next = 1'b1;
                        end
                        if (sent_ect0_reg != '0 && p0_reg == '0 &&
                            p1_reg > older_ect1_reg) begin
                            mangle_next = 1'b1;
                        end
                    end
                    older_ect1_next = last_ect1_reg;
                    last_ect0_next  = p0_reg;
                    last_ect1_next  = p1_reg;
                    last_ce_next    = pc_reg;
                    ce_sum_next     = ce_sum_reg + SUM_BITS'(diffc);
                end
            end
            EV_VALIDATE: begin
                if (phase_reg == PH_TESTING) begin
                    if (bleach_reg || mangle_reg) begin
                        phase_next        = PH_FAILED;
                        ect0_allowed_next = 1'b0;
                    end else if (marked_tx != '0 && enough_recv) begin
                        phase_next = PH_CAPABLE;
                    end else if (test_pkts_reg > COUNT_BITS'(MIN_TEST_PACKETS) &&
                                 marked_rx == '0) begin
                        phase_next        = PH_FAILED;
                        ect0_allowed_next = 1'b0;
                    end
                end
            end
            EV_CLEAR: begin
                sent_ect0_next  = '0;
                sent_ect1_next  = '0;
                sent_ce_next    = '0;
                last_ect0_next  = '0;
                last_ect1_next  = '0;
                last_ce_next    = '0;
                older_ect1_next = '0;
                test_pkts_next  = '0;
                ce_sum_next     = '0;
            end
            EV_BEGIN_TEST: begin
                if (phase_reg == PH_UNKNOWN) begin
                    phase_next = PH_TESTING;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            use_l4s_reg      <= 1'b0;
            tol_reg          <= TOL_RESET;
            phase_reg        <= PH_UNKNOWN;
            ect0_allowed_reg <= 1'b1;
            sent_ect0_reg    <= '0;
            sent_ect1_reg    <= '0;
            sent_ce_reg      <= '0;
            last_ect0_reg    <= '0;
            last_ect1_reg    <= '0;
            last_ce_reg      <= '0;
            older_ect1_reg   <= '0;
            test_pkts_reg    <= '0;
            ce_sum_reg       <= '0;
            bleach_reg       <= 1'b0;
            mangle_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_USE_L4S:     use_l4s_reg <= cfg_wdata[0];
                    CFG_REORDER_TOL: tol_reg     <= cfg_wdata[TOL_BITS-1:0];
                    default: ;
                endcase
            end

            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end

            if (advance) begin
                out_valid_reg    <= 1'b1;
                phase_reg        <= phase_next;
                ect0_allowed_reg <= ect0_allowed_next;
                sent_ect0_reg    <= sent_ect0_next;
                sent_ect1_reg    <= sent_ect1_next;
                sent_ce_reg      <= sent_ce_next;
                last_ect0_reg    <= last_ect0_next;
                last_ect1_reg    <= last_ect1_next;
                last_ce_reg      <= last_ce_next;
                older_ect1_reg   <= older_ect1_next;
                test_pkts_reg    <= test_pkts_next;
                ce_sum_reg       <= ce_sum_next;
                bleach_reg       <= bleach_next;
                mangle_reg       <= mangle_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg  <= s_tuser;
            cp_reg    <= in_beat.sent_codepoint;
            p0_reg    <= in_beat.peer_ect0_total[COUNT_BITS-1:0];
            p1_reg    <= in_beat.peer_ect1_total[COUNT_BITS-1:0];
            pc_reg    <= in_beat.peer_ce_total[COUNT_BITS-1:0];
            acked_reg <= in_beat.acked_count;
        end
        if (advance) begin
            status_reg <= status_next;
            d0_reg     <= d0_next;
            d1_reg     <= d1_next;
            dc_reg     <= dc_next;
            na_reg     <= na_next;
        end
    end

    // The path state always matches the beat held in the result register, as
    // both change on the same edge.
    always_comb begin
        if (phase_reg == PH_FAILED) begin
            send_mark = CP_NOT_ECT;
        end else if (use_l4s_reg) begin
            send_mark = CP_ECT1;
        end else if (ect0_allowed_reg) begin
            send_mark = CP_ECT0;
        end else begin
            send_mark = CP_NOT_ECT;
        end
    end

    always_comb begin
        out_beat.pad            = '0;
        out_beat.send_mark      = send_mark;
        out_beat.mangling_seen  = mangle_reg;
        out_beat.bleaching_seen = bleach_reg;
        out_beat.path_status    = phase_reg;
        out_beat.ce_accumulated = ce_sum_reg;
        out_beat.acked_pass     = na_reg;
        out_beat.ce_inc         = FIELD_BITS'(dc_reg);
        out_beat.ect1_inc       = FIELD_BITS'(d1_reg);
        out_beat.ect0_inc       = FIELD_BITS'(d0_reg);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_beat;
    assign m_tuser  = status_reg;

endmodule
